### design/bracket_balance_checker_macros.svh
// Assertion macros used by the bracket balance checker RTL.
// Depends on nothing; define ASSERT_OFF to compile all checks out.
`ifndef BRACKET_BALANCE_CHECKER_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted
`define BBC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bracket_balance_checker assertion failed");
// Clocked check that also holds during reset
`define BBC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bracket_balance_checker assertion failed");
`else
`define BBC_ASSERT(lbl, clk, rstn, prop)
`define BBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/bbc_pkg.sv
// Shared types, codes and the byte classifier of the bracket balance checker.
// No dependencies.
package bbc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 64;

    // Bracket kind codes
    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_FAIL    = 2'd1;
    localparam logic [1:0] VERDICT_BALANCE = 2'd2;
    localparam logic [1:0] VERDICT_UNBAL   = 2'd3;

    localparam int DEPTH_OUT_W = 7;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_END
    } op_t;

    // One classified request between front and back
    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
    } bbc_item_t;

    function automatic bbc_item_t classify(input logic [7:0] c, input logic eot);
        bbc_item_t item;
        item.op   = OP_NONE;
        item.kind = KIND_ROUND;
        if (eot) begin
            item.op = OP_END;
        end else begin
            unique case (c)
                8'h28: begin item.op = OP_PUSH; item.kind = KIND_ROUND;  end
                8'h5B: begin item.op = OP_PUSH; item.kind = KIND_SQUARE; end
                8'h7B: begin item.op = OP_PUSH; item.kind = KIND_CURLY;  end
                8'h29: begin item.op = OP_POP;  item.kind = KIND_ROUND;  end
                8'h5D: begin item.op = OP_POP;  item.kind = KIND_SQUARE; end
                8'h7D: begin item.op = OP_POP;  item.kind = KIND_CURLY;  end
                default: begin item.op = OP_NONE; end
            endcase
        end
        return item;
    endfunction

endpackage

### design/bbc_front.sv
// Front end: accepts input requests, classifies each byte, holds one
// classified request. Depends on bbc_pkg.
module bbc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_eot,
    output logic                out_valid,
    input  logic                out_ready,
    output bbc_pkg::bbc_item_t  out_item
);

    logic               valid_reg;
    bbc_pkg::bbc_item_t item_reg;

    // no request is taken while in reset
    assign in_ready  = aresetn && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Classification register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= bbc_pkg::classify(in_byte, in_eot);
        end
    end

endmodule

### design/bbc_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on bbc_pkg.
module bbc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  bbc_pkg::bbc_item_t  wr_item,
    output logic                rd_valid,
    input  logic                rd_ready,
    output bbc_pkg::bbc_item_t  rd_item
);

    bbc_pkg::bbc_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               wr_en;
    logic               rd_en;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 2'd1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### design/bbc_back.sv
// Back end: bracket stack engine and result register.
// Top of stack and the entry below it live in registers, the rest in a RAM.
// Depends on bbc_pkg and bracket_balance_checker_macros.svh.
`include "bracket_balance_checker_macros.svh"

module bbc_back #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bbc_pkg::bbc_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_verdict,
    output logic [bbc_pkg::DEPTH_OUT_W-1:0] out_depth
);

    localparam int DW     = $clog2(STACK_DEPTH + 1);
    localparam int MEM_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [1:0]    mem [STACK_DEPTH];
    logic [DW-1:0] depth_reg, depth_next;
    logic          failed_reg, failed_next;
    logic [1:0]    top_reg, top_next;
    logic [1:0]    below_reg;
    logic          out_valid_reg;
    logic [1:0]    verdict_reg, verdict_next;
    logic [DW-1:0] depth_out_reg;
    logic          fire;
    logic          do_push;
    logic          do_pop;
    logic [DW-1:0] wr_idx;
    logic [DW-1:0] rd_idx;
    logic [DW+bbc_pkg::DEPTH_OUT_W-1:0] depth_wide;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_verdict = verdict_reg;
    assign depth_wide  = {{bbc_pkg::DEPTH_OUT_W{1'b0}}, depth_out_reg};
    assign out_depth   = depth_wide[bbc_pkg::DEPTH_OUT_W-1:0];

    // Old top goes to entry depth-1; new below-top comes from entry depth-3
    assign wr_idx = depth_reg - DW'(1);
    assign rd_idx = depth_reg - DW'(3);

    // Next stack state and verdict
    always_comb begin
        depth_next   = depth_reg;
        failed_next  = failed_reg;
        top_next     = top_reg;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        verdict_next = bbc_pkg::VERDICT_OK;
        if (in_item.op == bbc_pkg::OP_END) begin
            verdict_next = (!failed_reg && depth_reg == '0) ?
                           bbc_pkg::VERDICT_BALANCE : bbc_pkg::VERDICT_UNBAL;
            depth_next   = '0;
            failed_next  = 1'b0;
        end else begin
            if (!failed_reg) begin
                unique case (in_item.op)
                    bbc_pkg::OP_PUSH: begin
                        if (depth_reg == DW'(STACK_DEPTH)) begin
                            failed_next = 1'b1;
                        end else begin
                            do_push    = 1'b1;
                            depth_next = depth_reg + DW'(1);
                            top_next   = in_item.kind;
                        end
                    end
                    bbc_pkg::OP_POP: begin
                        if (depth_reg == '0) begin
                            failed_next = 1'b1;
                        end else begin
                            do_pop     = 1'b1;
                            depth_next = depth_reg - DW'(1);
                            top_next   = below_reg;
                            if (top_reg != in_item.kind) begin
                                failed_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        depth_next = depth_reg;
                    end
                endcase
            end
            verdict_next = failed_next ? bbc_pkg::VERDICT_FAIL : bbc_pkg::VERDICT_OK;
        end
    end

    // Stack registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                depth_reg  <= depth_next;
                failed_reg <= failed_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
        if (fire) begin
            top_reg       <= top_next;
            verdict_reg   <= verdict_next;
            depth_out_reg <= depth_next;
        end
    end

    // Stack RAM: one write, one registered read into below_reg
    always_ff @(posedge aclk) begin
        if (fire && do_push && depth_reg != '0) begin
            mem[wr_idx[MEM_AW-1:0]] <= top_reg;
        end
        if (fire && do_push) begin
            below_reg <= top_reg;
        end else if (fire && do_pop) begin
            below_reg <= mem[rd_idx[MEM_AW-1:0]];
        end
    end

    `BBC_ASSERT(a_depth_bound, aclk, aresetn, depth_reg <= DW'(STACK_DEPTH))
    `BBC_ASSERT(a_end_clears, aclk, aresetn, (fire && in_item.op == bbc_pkg::OP_END) |=> (depth_reg == '0 && !failed_reg))
    `BBC_ASSERT(a_balance_empty, aclk, aresetn, (out_valid_reg && verdict_reg == bbc_pkg::VERDICT_BALANCE) |-> (depth_out_reg == '0))
    `BBC_ASSERT(a_failed_frozen, aclk, aresetn, (fire && failed_reg && in_item.op != bbc_pkg::OP_END) |=> $stable(depth_reg))

endmodule

### design/bracket_balance_checker.sv
// Bracket balance checker: one request per cycle sustained while m_tready stays high.
// Pipeline: the classify reg loads on accept, then the queue, then the result reg drives m_tvalid.
// Throughput: 1 byte per cycle while m_tready is high; the stack keeps top and next entry
//   in registers, so back-to-back pushes and pops each touch the stack RAM at most once.
// Reset: synchronous active-low aresetn clears depth, failure flag and all valids;
//   s_tready is low while in reset; the stack RAM is not cleared and needs no clearing pass.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] verdict, [8:2] open_depth, [15:9] zero
);

    logic               f_valid;
    logic               f_ready;
    bbc_pkg::bbc_item_t f_item;
    logic               q_valid;
    logic               q_ready;
    bbc_pkg::bbc_item_t q_item;
    logic [1:0]         verdict;
    logic [bbc_pkg::DEPTH_OUT_W-1:0] open_depth;

    bbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eot    (s_tuser[0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    bbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_verdict (verdict),
        .out_depth   (open_depth)
    );

    assign m_tdata = {7'b0, open_depth, verdict};

endmodule

### sim/bracket_balance_checker_tb.sv
// Self-checking testbench for bracket_balance_checker: streams texts of bracket bytes
// and terminators, predicts every verdict in a scoreboard class, and compares results.
// Depends on bbc_pkg and the bracket_balance_checker RTL only.
module bracket_balance_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT;
    localparam int N_ITEMS     = 1900;   // input requests to send
    localparam int STALL_LIMIT = 2000;   // cycles without any handshake on either side before giving up

    // Bracket characters, indexed by kind code
    localparam logic [7:0] OPEN_CH  [3] = '{8'h28, 8'h5B, 8'h7B};
    localparam logic [7:0] CLOSE_CH [3] = '{8'h29, 8'h5D, 8'h7D};

    typedef struct packed {
        logic [1:0] verdict;
        logic [6:0] open_depth;
    } bracket_result_t;

    typedef enum int {
        TXT_CLEAN,
        TXT_BROKEN,
        TXT_DEEP,
        TXT_NOISE
    } text_shape_t;

    // Returns 1 and the kind when c is one of the given bracket characters
    function automatic bit kind_lookup(input logic [7:0] c, input logic [7:0] chars [3],
                                       output logic [1:0] kind);
        kind = bbc_pkg::KIND_ROUND;
        for (int k = 0; k < 3; k++) begin
            if (c == chars[k]) begin
                kind = 2'(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Tracks the bracket stack and the verdict each request should produce
    class bracket_scoreboard;
        logic [1:0]      kind_stack [STACK_DEPTH];
        int unsigned     depth  = 0;
        bit              failed = 1'b0;
        int unsigned     errors = 0;
        bracket_result_t verdict_q [$];

        function void note_request(input logic [7:0] text_byte, input logic end_of_text);
            bracket_result_t res;
            logic [1:0]      okind;
            logic [1:0]      ckind;
            bit              is_open;
            bit              is_close;
            is_open  = kind_lookup(text_byte, OPEN_CH, okind);
            is_close = kind_lookup(text_byte, CLOSE_CH, ckind);
            if (end_of_text) begin
                res.verdict    = (!failed && depth == 0) ? bbc_pkg::VERDICT_BALANCE
                                                         : bbc_pkg::VERDICT_UNBAL;
                res.open_depth = '0;
                depth  = 0;
                failed = 1'b0;
            end else begin
                // once failed, text bytes are ignored until the terminator
                if (!failed) begin
                    if (is_open) begin
                        if (depth >= STACK_DEPTH) begin
                            failed = 1'b1;
                        end else begin
                            kind_stack[depth] = okind;
                            depth++;
                        end
                    end else if (is_close) begin
                        if (depth == 0) begin
                            failed = 1'b1;
                        end else begin
                            depth--;
                            if (kind_stack[depth] != ckind) failed = 1'b1;
                        end
                    end
                end
                res.verdict    = failed ? bbc_pkg::VERDICT_FAIL : bbc_pkg::VERDICT_OK;
                res.open_depth = 7'(depth);
            end
            verdict_q.push_back(res);
        endfunction

        function void check_result(input logic [15:0] data);
            bracket_result_t exp_res;
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", data);
                errors++;
                return;
            end
            exp_res = verdict_q.pop_front();
            if (data[1:0] !== exp_res.verdict) begin
                $error("verdict: expected %0d, got %0d", exp_res.verdict, data[1:0]);
                errors++;
            end
            if (data[8:2] !== exp_res.open_depth) begin
                $error("open_depth: expected %0d, got %0d", exp_res.open_depth, data[8:2]);
                errors++;
            end
            if (data[15:9] !== 7'd0) begin
                $error("tdata pad: expected 0, got %h", data[15:9]);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    bracket_scoreboard sb = new;
    logic [7:0]  text_q [$];
    bit          idle_on     = 1'b1;
    int unsigned counted     = 0;
    int unsigned stall_count = 0;

    bracket_balance_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Hold reset at the start, release it once
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Result side: random stall bursts, always ready near the end
    initial begin
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Result checking and progress tracking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Watchdog
    initial begin
        while (stall_count < STALL_LIMIT) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    function automatic bit is_bracket(input logic [7:0] c);
        logic [1:0] kind;
        return kind_lookup(c, OPEN_CH, kind) || kind_lookup(c, CLOSE_CH, kind);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_bracket(c));
        return c;
    endfunction

    // Send one request and wait for it to be taken, then maybe go idle
    task automatic send_req(input logic [7:0] text_byte, input logic end_of_text);
        s_tvalid <= 1'b1;
        s_tdata  <= text_byte;
        s_tuser  <= end_of_text;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(text_byte, end_of_text);
        counted++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Send the queued text followed by its terminator
    task automatic send_text(input logic [7:0] eot_byte);
        foreach (text_q[i]) send_req(text_q[i], 1'b0);
        send_req(eot_byte, 1'b1);
    endtask

    // Fill text_q with one text of the given shape
    task automatic build_text(input text_shape_t shape);
        logic [1:0]  open_kinds [$];
        logic [1:0]  kind;
        int unsigned cap;
        int unsigned steps;
        int unsigned n;
        int unsigned r;
        int          pos;
        int          closes [$];
        text_q.delete();
        case (shape)
            TXT_CLEAN, TXT_BROKEN: begin
                cap   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, STACK_DEPTH)
                                                    : $urandom_range(1, 8);
                steps = cap + $urandom_range(2, 40);
                repeat (steps) begin
                    r = $urandom_range(0, 9);
                    if (r < 4 && open_kinds.size() < cap) begin
                        kind = 2'($urandom_range(bbc_pkg::KIND_ROUND, bbc_pkg::KIND_CURLY));
                        open_kinds.push_back(kind);
                        text_q.push_back(OPEN_CH[kind]);
                    end else if (r < 7 && open_kinds.size() > 0) begin
                        text_q.push_back(CLOSE_CH[open_kinds.pop_back()]);
                    end else begin
                        text_q.push_back(noise_byte());
                    end
                end
                while (open_kinds.size() > 0) text_q.push_back(CLOSE_CH[open_kinds.pop_back()]);
                if (shape == TXT_BROKEN) begin
                    foreach (text_q[i]) begin
                        if (kind_lookup(text_q[i], CLOSE_CH, kind)) closes.push_back(i);
                    end
                    pos = $urandom_range(0, text_q.size());
                    r   = $urandom_range(0, 3);
                    if (closes.size() == 0 && r < 2) r = 2;
                    case (r)
                        0: begin
                            // close of the wrong kind
                            pos = closes[$urandom_range(0, closes.size() - 1)];
                            void'(kind_lookup(text_q[pos], CLOSE_CH, kind));
                            text_q[pos] = CLOSE_CH[(kind + 1 + $urandom_range(0, 1)) % 3];
                        end
                        1: text_q.delete(closes[$urandom_range(0, closes.size() - 1)]);
                        2: text_q.insert(pos, CLOSE_CH[$urandom_range(0, 2)]);
                        default: text_q.insert(pos, OPEN_CH[$urandom_range(0, 2)]);
                    endcase
                end
            end
            TXT_DEEP: begin
                // fill the stack to around its capacity, past it sometimes
                n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
                repeat (n) begin
                    kind = 2'($urandom_range(bbc_pkg::KIND_ROUND, bbc_pkg::KIND_CURLY));
                    if (open_kinds.size() < STACK_DEPTH) open_kinds.push_back(kind);
                    text_q.push_back(OPEN_CH[kind]);
                end
                repeat ($urandom_range(0, open_kinds.size())) begin
                    text_q.push_back(CLOSE_CH[open_kinds.pop_back()]);
                end
            end
            default: begin
                repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Stimulus
    initial begin
        int unsigned   text_no;
        int unsigned   r;
        text_shape_t   shape;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // empty text, terminator byte at its low extreme
        text_q = {};
        send_text(8'h00);
        text_q = '{OPEN_CH[bbc_pkg::KIND_ROUND], CLOSE_CH[bbc_pkg::KIND_ROUND]};
        send_text(8'hFF);
        // nesting with other bytes at both extremes in between
        text_q = '{OPEN_CH[bbc_pkg::KIND_SQUARE], OPEN_CH[bbc_pkg::KIND_CURLY], 8'hFF, 8'h00,
                   CLOSE_CH[bbc_pkg::KIND_CURLY], CLOSE_CH[bbc_pkg::KIND_SQUARE]};
        send_text(8'h5A);
        // close on empty stack, later bytes ignored
        text_q = '{CLOSE_CH[bbc_pkg::KIND_CURLY], OPEN_CH[bbc_pkg::KIND_ROUND]};
        send_text(8'hA5);
        // kind mismatch, later bytes ignored
        text_q = '{OPEN_CH[bbc_pkg::KIND_ROUND], CLOSE_CH[bbc_pkg::KIND_SQUARE],
                   OPEN_CH[bbc_pkg::KIND_SQUARE]};
        send_text(8'h00);
        // open bracket left at the end
        text_q = '{OPEN_CH[bbc_pkg::KIND_CURLY]};
        send_text(8'hFF);
        // terminator carrying a bracket byte, which must be ignored
        text_q = {};
        send_text(OPEN_CH[bbc_pkg::KIND_ROUND]);

        // random texts, the first one filling the stack to around its capacity
        text_no = 0;
        while (counted < N_ITEMS) begin
            if (counted >= N_ITEMS * 85 / 100) idle_on = 1'b0;
            r = $urandom_range(0, 19);
            if (text_no == 0)  shape = TXT_DEEP;
            else if (r < 10)   shape = TXT_CLEAN;
            else if (r < 16)   shape = TXT_BROKEN;
            else if (r < 17)   shape = TXT_DEEP;
            else               shape = TXT_NOISE;
            build_text(shape);
            send_text(8'($urandom_range(0, 255)));
            text_no++;
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
